[src/dual_sensor_throttle_check_scale_defines.svh]
// Assertion macros for the throttle check block.
// Taken in by the checker file; needs nothing else.
`ifndef DUAL_SENSOR_THROTTLE_CHECK_SCALE_DEFINES_SVH
`define DUAL_SENSOR_THROTTLE_CHECK_SCALE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DSTCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dstcs checker: property failed");

// Next-cycle implication, disabled during reset.
`define DSTCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dstcs checker: property failed");

`endif

[src/dstcs_pkg.sv]
// Shared codes, types and register defaults of the throttle check block.
// No dependencies.
package dstcs_pkg;

    typedef logic [1:0] t_fault;
    typedef logic [1:0] t_mode;

    localparam t_fault FAULT_NONE = 2'd0;
    localparam t_fault FAULT_A    = 2'd1;
    localparam t_fault FAULT_B    = 2'd2;
    localparam t_fault FAULT_DIS  = 2'd3;

    // How the back end forms the drive value.
    localparam t_mode MODE_MIN  = 2'd0;
    localparam t_mode MODE_MAX  = 2'd1;
    localparam t_mode MODE_RAMP = 2'd2;

    typedef struct packed {
        t_fault fault;
        t_mode  mode;
    } t_ctl;

    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_DZ_LOW  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DZ_HIGH = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_AGREE   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_VLD_LOW = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_VLD_HI  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_DRV_MAX = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_DRV_MIN = 3'd6;

    localparam int RST_DZ_LOW  = 100;
    localparam int RST_DZ_HIGH = 4000;
    localparam int RST_AGREE   = 200;
    localparam int RST_VLD_LOW = 500;
    localparam int RST_VLD_HI  = 3500;
    localparam int RST_DRV_MAX = 1023;
    localparam int RST_DRV_MIN = 0;

endpackage

[src/dstcs_in_if.sv]
// Input channel of the throttle check block: one sensor pair per word.
// No dependencies.
interface dstcs_in_if #(
    parameter int SAMPLE_BITS = 12
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;

    modport source (output valid, output sample_a, output sample_b, input ready);
    modport sink   (input valid, input sample_a, input sample_b, output ready);
endinterface

[src/dstcs_out_if.sv]
// Output channel of the throttle check block: drive value and fault code.
// No dependencies.
interface dstcs_out_if #(
    parameter int DRIVE_BITS = 10
) ();
    logic                  valid;
    logic                  ready;
    logic [DRIVE_BITS-1:0] drive_value;
    logic [1:0]            fault_code;

    modport source (output valid, output drive_value, output fault_code, input ready);
    modport sink   (input valid, input drive_value, input fault_code, output ready);
endinterface

[src/dstcs_front.sv]
// Front end: accepts sensor pairs, classifies faults and drive mode, multiplies.
// Depends on dstcs_pkg and dstcs_in_if.
module dstcs_front
    import dstcs_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int DRIVE_BITS  = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dstcs_in_if.sink                        i_in,
    input  logic [SAMPLE_BITS-1:0]          i_dz_low,
    input  logic [SAMPLE_BITS-1:0]          i_dz_high,
    input  logic [SAMPLE_BITS-1:0]          i_agree,
    input  logic [SAMPLE_BITS-1:0]          i_vld_low,
    input  logic [SAMPLE_BITS-1:0]          i_vld_high,
    input  logic [DRIVE_BITS-1:0]           i_drv_max,
    output logic                            o_valid,
    input  logic                            i_ready,
    output t_ctl                            o_ctl,
    output logic [SAMPLE_BITS+DRIVE_BITS-1:0] o_prod,
    output logic [SAMPLE_BITS-1:0]          o_span
);

    localparam int PROD_BITS = SAMPLE_BITS + DRIVE_BITS;

    logic                   r_valid;
    t_ctl                   r_ctl;
    t_ctl                   n_ctl;
    logic [PROD_BITS-1:0]   r_prod;
    logic [PROD_BITS-1:0]   n_prod;
    logic [SAMPLE_BITS-1:0] r_span;
    logic [SAMPLE_BITS-1:0] n_span;

    logic [SAMPLE_BITS-1:0] w_a;
    logic [SAMPLE_BITS-1:0] w_b;
    logic [SAMPLE_BITS-1:0] w_diff;
    logic [SAMPLE_BITS-1:0] w_ofs;
    logic                   w_take;

    assign w_a    = i_in.sample_a;
    assign w_b    = i_in.sample_b;
    assign i_in.ready = !r_valid || i_ready;
    assign w_take = i_in.valid && i_in.ready;

    always_comb begin
        w_diff = (w_a > w_b) ? (w_a - w_b) : (w_b - w_a);
        w_ofs  = w_a - i_vld_low;
        n_span = i_vld_high - i_vld_low;
        n_prod = PROD_BITS'(w_ofs) * PROD_BITS'(i_drv_max);

        if ((w_a < i_dz_low) || (w_a > i_dz_high)) begin
            n_ctl.fault = FAULT_A;
        end else if ((w_b < i_dz_low) || (w_b > i_dz_high)) begin
            n_ctl.fault = FAULT_B;
        end else if (w_diff > i_agree) begin
            n_ctl.fault = FAULT_DIS;
        end else begin
            n_ctl.fault = FAULT_NONE;
        end

        // Low bound is tested first; a ramp word always lies inside a non-empty window.
        if (n_ctl.fault != FAULT_NONE) begin
            n_ctl.mode = MODE_MIN;
        end else if (w_a <= i_vld_low) begin
            n_ctl.mode = MODE_MAX;
        end else if (w_a >= i_vld_high) begin
            n_ctl.mode = MODE_MIN;
        end else begin
            n_ctl.mode = MODE_RAMP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_ctl  <= n_ctl;
            r_prod <= n_prod;
            r_span <= n_span;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_prod  = r_prod;
    assign o_span  = r_span;

endmodule

[src/dstcs_fifo.sv]
// Two-entry queue between front and back ends.
// No dependencies.
module dstcs_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[src/dstcs_back.sv]
// Back end: restoring divider, one quotient bit per stage, then the drive select.
// Depends on dstcs_pkg and dstcs_out_if.
module dstcs_back
    import dstcs_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int DRIVE_BITS  = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  t_ctl                              i_ctl,
    input  logic [SAMPLE_BITS+DRIVE_BITS-1:0] i_prod,
    input  logic [SAMPLE_BITS-1:0]            i_span,
    input  logic [DRIVE_BITS-1:0]             i_drv_max,
    input  logic [DRIVE_BITS-1:0]             i_drv_min,
    dstcs_out_if.source                       o_out
);

    localparam int PROD_BITS = SAMPLE_BITS + DRIVE_BITS;

    // Stage registers: entry k holds the word after k+1 division steps.
    logic                   r_v    [DRIVE_BITS];
    t_ctl                   r_ctl  [DRIVE_BITS];
    logic [SAMPLE_BITS-1:0] r_rem  [DRIVE_BITS];
    logic [DRIVE_BITS-1:0]  r_low  [DRIVE_BITS];
    logic [DRIVE_BITS-1:0]  r_q    [DRIVE_BITS];
    logic [SAMPLE_BITS-1:0] r_span [DRIVE_BITS];

    logic                   w_v_in    [DRIVE_BITS];
    t_ctl                   w_ctl_in  [DRIVE_BITS];
    logic [SAMPLE_BITS-1:0] w_rem_in  [DRIVE_BITS];
    logic [DRIVE_BITS-1:0]  w_low_in  [DRIVE_BITS];
    logic [DRIVE_BITS-1:0]  w_q_in    [DRIVE_BITS];
    logic [SAMPLE_BITS-1:0] w_span_in [DRIVE_BITS];
    logic                   w_rdy     [DRIVE_BITS+1];

    logic                   r_out_v;
    logic [DRIVE_BITS-1:0]  r_drive;
    logic [DRIVE_BITS-1:0]  n_drive;
    t_fault                 r_fault;
    logic [DRIVE_BITS-1:0]  w_part;
    t_ctl                   w_last_ctl;
    logic [DRIVE_BITS-1:0]  w_last_q;

    assign w_rdy[DRIVE_BITS] = !r_out_v || o_out.ready;
    assign o_ready           = w_rdy[0];

    genvar k;
    generate
        for (k = 0; k < DRIVE_BITS; k++) begin : g_stage
            logic [SAMPLE_BITS:0]   w_trial;
            logic                   w_fit;
            logic [SAMPLE_BITS:0]   w_sub;

            if (k == 0) begin : g_head
                // Upper part of the product is below the span for a ramp word.
                assign w_v_in[k]    = i_valid;
                assign w_ctl_in[k]  = i_ctl;
                assign w_rem_in[k]  = i_prod[PROD_BITS-1:DRIVE_BITS];
                assign w_low_in[k]  = i_prod[DRIVE_BITS-1:0];
                assign w_q_in[k]    = '0;
                assign w_span_in[k] = i_span;
            end else begin : g_body
                assign w_v_in[k]    = r_v[k-1];
                assign w_ctl_in[k]  = r_ctl[k-1];
                assign w_rem_in[k]  = r_rem[k-1];
                assign w_low_in[k]  = r_low[k-1];
                assign w_q_in[k]    = r_q[k-1];
                assign w_span_in[k] = r_span[k-1];
            end

            assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
            assign w_trial  = {w_rem_in[k], w_low_in[k][DRIVE_BITS-1]};
            assign w_fit    = (w_trial >= {1'b0, w_span_in[k]});
            assign w_sub    = w_trial - {1'b0, w_span_in[k]};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (w_rdy[k]) begin
                    r_v[k] <= w_v_in[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[k] && w_v_in[k]) begin
                    r_ctl[k]  <= w_ctl_in[k];
                    r_rem[k]  <= w_fit ? w_sub[SAMPLE_BITS-1:0] : w_trial[SAMPLE_BITS-1:0];
                    r_low[k]  <= {w_low_in[k][DRIVE_BITS-2:0], 1'b0};
                    r_q[k]    <= {w_q_in[k][DRIVE_BITS-2:0], w_fit};
                    r_span[k] <= w_span_in[k];
                end
            end
        end
    endgenerate

    assign w_last_ctl = r_ctl[DRIVE_BITS-1];
    assign w_last_q   = r_q[DRIVE_BITS-1];

    always_comb begin
        w_part = (w_last_q > i_drv_max) ? i_drv_max : w_last_q;
        case (w_last_ctl.mode)
            MODE_MAX:  n_drive = i_drv_max;
            MODE_RAMP: n_drive = i_drv_max - w_part;
            default:   n_drive = i_drv_min;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_rdy[DRIVE_BITS]) begin
            r_out_v <= r_v[DRIVE_BITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[DRIVE_BITS] && r_v[DRIVE_BITS-1]) begin
            r_drive <= n_drive;
            r_fault <= w_last_ctl.fault;
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.drive_value = r_drive;
    assign o_out.fault_code  = r_fault;

endmodule

[src/dual_sensor_throttle_check_scale.sv]
// Dual throttle sensor plausibility check and inverted drive scaling.
// Throughput: one word per cycle unless the output stalls; the divider is a pipeline
// of DRIVE_BITS stages, one quotient bit each, behind a classify and multiply stage
// and a two-entry queue.
// Reset: synchronous, active low; empties all stages and the queue and restores
// the configuration registers to their defaults. No clearing pass.
module dual_sensor_throttle_check_scale
    import dstcs_pkg::*;
#(
    parameter int  SAMPLE_BITS = 12,
    parameter int  DRIVE_BITS  = 10,
    localparam int CFG_BITS    = (SAMPLE_BITS > DRIVE_BITS) ? SAMPLE_BITS : DRIVE_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    dstcs_in_if.sink                i_in,
    dstcs_out_if.source             o_out
);

    localparam int PROD_BITS  = SAMPLE_BITS + DRIVE_BITS;
    localparam int QUEUE_BITS = $bits(t_ctl) + PROD_BITS + SAMPLE_BITS;

    logic [SAMPLE_BITS-1:0] r_dz_low;
    logic [SAMPLE_BITS-1:0] r_dz_high;
    logic [SAMPLE_BITS-1:0] r_agree;
    logic [SAMPLE_BITS-1:0] r_vld_low;
    logic [SAMPLE_BITS-1:0] r_vld_high;
    logic [DRIVE_BITS-1:0]  r_drv_max;
    logic [DRIVE_BITS-1:0]  r_drv_min;

    logic                   w_f_valid;
    logic                   w_f_ready;
    t_ctl                   w_f_ctl;
    logic [PROD_BITS-1:0]   w_f_prod;
    logic [SAMPLE_BITS-1:0] w_f_span;

    logic                   w_q_valid;
    logic                   w_q_ready;
    logic [QUEUE_BITS-1:0]  w_q_data;
    t_ctl                   w_b_ctl;
    logic [PROD_BITS-1:0]   w_b_prod;
    logic [SAMPLE_BITS-1:0] w_b_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz_low   <= SAMPLE_BITS'(RST_DZ_LOW);
            r_dz_high  <= SAMPLE_BITS'(RST_DZ_HIGH);
            r_agree    <= SAMPLE_BITS'(RST_AGREE);
            r_vld_low  <= SAMPLE_BITS'(RST_VLD_LOW);
            r_vld_high <= SAMPLE_BITS'(RST_VLD_HI);
            r_drv_max  <= DRIVE_BITS'(RST_DRV_MAX);
            r_drv_min  <= DRIVE_BITS'(RST_DRV_MIN);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DZ_LOW:  r_dz_low   <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_DZ_HIGH: r_dz_high  <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_AGREE:   r_agree    <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_VLD_LOW: r_vld_low  <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_VLD_HI:  r_vld_high <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_DRV_MAX: r_drv_max  <= i_cfg_data[DRIVE_BITS-1:0];
                REG_DRV_MIN: r_drv_min  <= i_cfg_data[DRIVE_BITS-1:0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    dstcs_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DRIVE_BITS  (DRIVE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_dz_low   (r_dz_low),
        .i_dz_high  (r_dz_high),
        .i_agree    (r_agree),
        .i_vld_low  (r_vld_low),
        .i_vld_high (r_vld_high),
        .i_drv_max  (r_drv_max),
        .o_valid    (w_f_valid),
        .i_ready    (w_f_ready),
        .o_ctl      (w_f_ctl),
        .o_prod     (w_f_prod),
        .o_span     (w_f_span)
    );

    dstcs_fifo #(
        .WIDTH (QUEUE_BITS)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  ({w_f_ctl, w_f_prod, w_f_span}),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_data)
    );

    assign {w_b_ctl, w_b_prod, w_b_span} = w_q_data;

    dstcs_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DRIVE_BITS  (DRIVE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_q_valid),
        .o_ready   (w_q_ready),
        .i_ctl     (w_b_ctl),
        .i_prod    (w_b_prod),
        .i_span    (w_b_span),
        .i_drv_max (r_drv_max),
        .i_drv_min (r_drv_min),
        .o_out     (o_out)
    );

endmodule

[src/dstcs_checker.sv]
// Port-level checks of the throttle check block, bound to the top level.
// Depends on dstcs_pkg and dual_sensor_throttle_check_scale_defines.svh.
`include "dual_sensor_throttle_check_scale_defines.svh"

module dstcs_checker
    import dstcs_pkg::*;
#(
    parameter int  SAMPLE_BITS = 12,
    parameter int  DRIVE_BITS  = 10,
    localparam int CFG_BITS    = (SAMPLE_BITS > DRIVE_BITS) ? SAMPLE_BITS : DRIVE_BITS
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_cfg_we,
    input logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input logic [CFG_BITS-1:0]     i_cfg_data,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [DRIVE_BITS-1:0]   i_drive_value,
    input logic [1:0]              i_fault_code
);

    logic [DRIVE_BITS-1:0] r_drv_max;
    logic [DRIVE_BITS-1:0] r_drv_min;
    logic [5:0]            r_pending;
    logic                  w_in_acc;
    logic                  w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    // Shadow the drive limits from the write port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drv_max <= DRIVE_BITS'(RST_DRV_MAX);
            r_drv_min <= DRIVE_BITS'(RST_DRV_MIN);
        end else if (i_cfg_we && (i_cfg_idx == REG_DRV_MAX)) begin
            r_drv_max <= i_cfg_data[DRIVE_BITS-1:0];
        end else if (i_cfg_we && (i_cfg_idx == REG_DRV_MIN)) begin
            r_drv_min <= i_cfg_data[DRIVE_BITS-1:0];
        end
    end

    // Count words taken in but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_pending <= r_pending + 6'd1;
        end else if (w_out_acc && !w_in_acc) begin
            r_pending <= r_pending - 6'd1;
        end
    end

    `DSTCS_ASSERT_IMP(a_fault_min, i_clk, i_rst_n, i_out_valid && (i_fault_code != FAULT_NONE), i_drive_value == r_drv_min)
    `DSTCS_ASSERT_IMP(a_drive_range, i_clk, i_rst_n, i_out_valid && (i_fault_code == FAULT_NONE), (i_drive_value <= r_drv_max) || (i_drive_value == r_drv_min))
    `DSTCS_ASSERT_IMP(a_no_invent, i_clk, i_rst_n, w_out_acc, r_pending != 6'd0)
    `DSTCS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_drive_value) && $stable(i_fault_code))

endmodule

bind dual_sensor_throttle_check_scale dstcs_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DRIVE_BITS  (DRIVE_BITS)
) u_dstcs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_idx     (i_cfg_idx),
    .i_cfg_data    (i_cfg_data),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_drive_value (o_out.drive_value),
    .i_fault_code  (o_out.fault_code)
);
